/* hw/rtl/irp_pkg.sv */
// ----------------------------------------------------------------------------
// irp_pkg
// Shared types and constants of the image report packetizer.
// ----------------------------------------------------------------------------
package irp_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 4096;
  localparam int unsigned MAX_IMAGE_DEF    = 65536;
  localparam int unsigned PANEL_SIZE_DEF   = 512;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;

  // packet offsets and pad counts fit 13 bits over the whole packet size range
  localparam int unsigned POS_W   = 13;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned HIDX_W  = 5;

  localparam logic [POS_W-1:0]  FIRST_HDR_LEN = POS_W'(20);
  localparam logic [POS_W-1:0]  NEXT_HDR_LEN  = POS_W'(5);
  localparam logic [HIDX_W-1:0] FIRST_HDR_IDX = HIDX_W'(20);
  localparam logic [HIDX_W-1:0] NEXT_HDR_IDX  = HIDX_W'(5);

  localparam logic [3:0] FUNC_CODE   = 4'h2;
  localparam logic [7:0] IMAGE_COUNT = 8'h01;
  localparam logic [7:0] IMAGE_FMT   = 8'h00;

  localparam int unsigned APB_AW = 5;

  typedef enum logic [2:0] {
    REG_FEATURE  = 3'd0,
    REG_DEFER    = 3'd1,
    REG_ORIGIN   = 3'd2,
    REG_SIZE     = 3'd3,
    REG_LENGTH   = 3'd4,
    REG_REPORT   = 3'd5,
    REG_DEVICE   = 3'd6,
    REG_SW_DISP  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]       feature_index;
    logic             defer_update;
    logic [31:0]      region_origin;
    logic [31:0]      region_size;
    logic [LEN_W-1:0] image_length;
    logic [7:0]       report_id;
    logic [7:0]       device_index;
    logic [11:0]      software_and_display;
  } cfg_t;

  typedef enum logic [1:0] {
    ENT_PAYLOAD   = 2'd0,
    ENT_HDR_FIRST = 2'd1,
    ENT_HDR_NEXT  = 2'd2,
    ENT_REJECT    = 2'd3
  } ent_kind_e;

  // one classified input byte, as handed from front to back
  typedef struct packed {
    ent_kind_e        kind;
    logic [7:0]       data;
    logic [7:0]       seq;
    logic             eop;
    logic [POS_W-1:0] pad;
  } qent_t;

endpackage

/* hw/rtl/irp_front.sv */
// ----------------------------------------------------------------------------
// irp_front
// Accepts image bytes, checks the configuration and tracks packet position,
// sequence count and bytes sent; pushes one classified entry per kept byte.
// ----------------------------------------------------------------------------
module irp_front #(
  parameter int unsigned PACKET_BYTES = irp_pkg::PACKET_BYTES_DEF,
  parameter int unsigned MAX_IMAGE    = irp_pkg::MAX_IMAGE_DEF,
  parameter int unsigned PANEL_SIZE   = irp_pkg::PANEL_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irp_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output irp_pkg::qent_t      q_ent_o
);

  localparam logic [irp_pkg::POS_W-1:0] PktBytes = irp_pkg::POS_W'(PACKET_BYTES);
  localparam logic [irp_pkg::LEN_W-1:0] PktBytesL = irp_pkg::LEN_W'(PACKET_BYTES);
  localparam logic [irp_pkg::LEN_W-1:0] MaxImage = irp_pkg::LEN_W'(MAX_IMAGE);
  localparam logic [16:0] PanelSize = 17'(PANEL_SIZE);

  logic [irp_pkg::LEN_W-1:0] sent_q, sent_d;
  logic [irp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [3:0]                seqc_q, seqc_d;

  logic                      cfg_ok, done, accept, first, last, opens, eop;
  logic [16:0]               x_end, y_end;
  logic [15:0]               w, h;
  logic [irp_pkg::POS_W-1:0] hdr_len, pos_inc;
  logic [irp_pkg::LEN_W-1:0] remain, sent_inc;

  assign w     = cfg_i.region_size[31:16];
  assign h     = cfg_i.region_size[15:0];
  assign x_end = {1'b0, cfg_i.region_origin[31:16]} + {1'b0, w};
  assign y_end = {1'b0, cfg_i.region_origin[15:0]} + {1'b0, h};

  assign cfg_ok = (cfg_i.image_length != '0) && (cfg_i.image_length <= MaxImage) &&
                  (w != '0) && (h != '0) && (x_end <= PanelSize) && (y_end <= PanelSize);

  assign done   = sent_q >= cfg_i.image_length;
  assign opens  = pos_q == '0;
  assign first  = sent_q == '0;
  assign hdr_len = first ? irp_pkg::FIRST_HDR_LEN : irp_pkg::NEXT_HDR_LEN;
  assign remain = cfg_i.image_length - sent_q;
  assign last   = remain <= (PktBytesL - irp_pkg::LEN_W'(hdr_len));

  assign pos_inc  = (opens ? hdr_len : pos_q) + irp_pkg::POS_W'(1);
  assign sent_inc = sent_q + irp_pkg::LEN_W'(1);
  assign eop      = (pos_inc >= PktBytes) || (sent_inc >= cfg_i.image_length);

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  // a byte past the end of the image is dropped without a result if cfg_ok
  assign q_push_o   = accept && (!cfg_ok || !done);

  always_comb begin
    q_ent_o.data = in_byte_i;
    q_ent_o.seq  = {first, last, 1'b1, 1'b0, seqc_q + 4'd1};
    q_ent_o.eop  = eop;
    q_ent_o.pad  = (eop && (pos_inc < PktBytes)) ? PktBytes - pos_inc : '0;
    if (!cfg_ok) begin
      q_ent_o.kind = irp_pkg::ENT_REJECT;
    end else if (opens) begin
      q_ent_o.kind = first ? irp_pkg::ENT_HDR_FIRST : irp_pkg::ENT_HDR_NEXT;
    end else begin
      q_ent_o.kind = irp_pkg::ENT_PAYLOAD;
    end
  end

  always_comb begin
    sent_d = sent_q;
    pos_d  = pos_q;
    seqc_d = seqc_q;
    if (accept && cfg_ok && !done) begin
      sent_d = sent_inc;
      pos_d  = eop ? '0 : pos_inc;
      if (opens) begin
        seqc_d = seqc_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
      pos_q  <= '0;
      seqc_q <= '0;
    end else begin
      sent_q <= sent_d;
      pos_q  <= pos_d;
      seqc_q <= seqc_d;
    end
  end

  // packet offset never reaches the packet size while held
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PktBytes)
    else $error("packet position out of range");

endmodule

/* hw/rtl/irp_queue.sv */
// ----------------------------------------------------------------------------
// irp_queue
// Short register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module irp_queue #(
  parameter int unsigned DEPTH = irp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  irp_pkg::qent_t push_ent_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output irp_pkg::qent_t head_ent_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Depth = CntW'(DEPTH);

  irp_pkg::qent_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == Depth;
  assign head_valid_o = cnt_q != '0;
  assign head_ent_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue pop while empty");

endmodule

/* hw/rtl/irp_back.sv */
// ----------------------------------------------------------------------------
// irp_back
// Expands queue entries into header, payload and rejected beats and holds
// them in an output register until taken.
// ----------------------------------------------------------------------------
module irp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  irp_pkg::cfg_t             cfg_i,
  input  logic                      head_valid_i,
  input  irp_pkg::qent_t            head_ent_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      out_eop_o,
  output logic [irp_pkg::POS_W-1:0] out_pad_o,
  output logic                      out_last_o,
  output logic                      out_rej_o
);

  function automatic logic [7:0] hdr_byte(irp_pkg::cfg_t c,
                                          logic [irp_pkg::HIDX_W-1:0] idx,
                                          logic [7:0] seq);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = c.report_id;
      5'd1:    b = c.device_index;
      5'd2:    b = c.feature_index;
      5'd3:    b = {irp_pkg::FUNC_CODE, c.software_and_display[11:8]};
      5'd4:    b = seq;
      5'd5:    b = c.software_and_display[7:0];
      5'd6:    b = {7'd0, c.defer_update};
      5'd7:    b = irp_pkg::IMAGE_COUNT;
      5'd8:    b = irp_pkg::IMAGE_FMT;
      5'd9:    b = c.region_origin[31:24];
      5'd10:   b = c.region_origin[23:16];
      5'd11:   b = c.region_origin[15:8];
      5'd12:   b = c.region_origin[7:0];
      5'd13:   b = c.region_size[31:24];
      5'd14:   b = c.region_size[23:16];
      5'd15:   b = c.region_size[15:8];
      5'd16:   b = c.region_size[7:0];
      5'd17:   b = c.image_length[23:16];
      5'd18:   b = c.image_length[15:8];
      5'd19:   b = c.image_length[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  logic [irp_pkg::HIDX_W-1:0] idx_q, idx_d, hdr_end;
  logic                       load, final_beat, is_rej;
  logic                       vld_q, vld_d;
  logic [7:0]                 byte_q, byte_d;
  logic                       eop_q, eop_d, last_q, last_d, rej_q, rej_d;
  logic [irp_pkg::POS_W-1:0]  pad_q, pad_d;

  always_comb begin
    case (head_ent_i.kind)
      irp_pkg::ENT_HDR_FIRST: hdr_end = irp_pkg::FIRST_HDR_IDX;
      irp_pkg::ENT_HDR_NEXT:  hdr_end = irp_pkg::NEXT_HDR_IDX;
      default:                hdr_end = '0;
    endcase
  end

  assign is_rej     = head_ent_i.kind == irp_pkg::ENT_REJECT;
  assign final_beat = is_rej || (idx_q == hdr_end);
  assign load       = head_valid_i && (!vld_q || out_ready_i);
  assign pop_o      = load && final_beat;

  always_comb begin
    vld_d  = vld_q;
    idx_d  = idx_q;
    byte_d = byte_q;
    eop_d  = eop_q;
    pad_d  = pad_q;
    last_d = last_q;
    rej_d  = rej_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (load) begin
      vld_d  = 1'b1;
      idx_d  = final_beat ? '0 : idx_q + irp_pkg::HIDX_W'(1);
      last_d = final_beat;
      rej_d  = is_rej;
      eop_d  = final_beat && !is_rej && head_ent_i.eop;
      pad_d  = (final_beat && !is_rej) ? head_ent_i.pad : '0;
      if (is_rej) begin
        byte_d = 8'd0;
      end else if (final_beat) begin
        byte_d = head_ent_i.data;
      end else begin
        byte_d = hdr_byte(cfg_i, idx_q, head_ent_i.seq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eop_q  <= eop_d;
    pad_q  <= pad_d;
    last_q <= last_d;
    rej_q  <= rej_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_eop_o   = eop_q;
  assign out_pad_o   = pad_q;
  assign out_last_o  = last_q;
  assign out_rej_o   = rej_q;

  a_rej_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && rej_q) |-> (last_q && !eop_q && byte_q == 8'd0 && pad_q == '0))
    else $error("rejected beat malformed");

  a_eop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && (eop_q || pad_q != '0)) |-> last_q)
    else $error("end of packet not on final beat of a run");

  a_hdr_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= irp_pkg::FIRST_HDR_IDX)
    else $error("header index out of range");

endmodule

/* hw/rtl/image_report_packetizer.sv */
// ----------------------------------------------------------------------------
// image_report_packetizer
// Cuts a stream of image bytes into report packets with headers.
// ----------------------------------------------------------------------------
// Each image byte gives one output beat, preceded by a 20-byte header when it
// opens the first packet or a 5-byte header when it opens a later packet, so a
// byte yields 1, 6 or 21 beats, sent one per cycle from the back end's output
// register while m_axis_tready is high. Inputs are taken one per cycle while
// the front-to-back queue (four entries by default) has room, so payload bytes
// flow at one per cycle unless the output stalls; a header burst stalls input
// only once the queue fills. An invalid configuration turns each input byte
// into a single rejected beat; bytes beyond image_length give no beat. The
// user writes registers only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module image_report_packetizer #(
  parameter int unsigned PACKET_BYTES = irp_pkg::PACKET_BYTES_DEF,
  parameter int unsigned MAX_IMAGE    = irp_pkg::MAX_IMAGE_DEF,
  parameter int unsigned PANEL_SIZE   = irp_pkg::PANEL_SIZE_DEF,
  parameter int unsigned QUEUE_DEPTH  = irp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [irp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // image input
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] image_byte
  // packet output
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,   // [7:0] packet_byte, [20:8] pad_count
  output logic                       m_axis_tlast,   // run_last
  output logic [1:0]                 m_axis_tuser    // [0] end_of_packet, [1] rejected
);

  irp_pkg::cfg_t            cfg_q, cfg_d;
  irp_pkg::reg_idx_e        reg_sel;
  irp_pkg::qent_t           push_ent, head_ent;
  logic                     cfg_wr, q_full, q_push, q_pop, head_valid;
  logic [7:0]               out_byte;
  logic [irp_pkg::POS_W-1:0] out_pad;
  logic                     out_eop, out_rej;

  assign pready  = 1'b1;
  assign reg_sel = irp_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        irp_pkg::REG_FEATURE: cfg_d.feature_index        = pwdata[7:0];
        irp_pkg::REG_DEFER:   cfg_d.defer_update         = pwdata[0];
        irp_pkg::REG_ORIGIN:  cfg_d.region_origin        = pwdata;
        irp_pkg::REG_SIZE:    cfg_d.region_size          = pwdata;
        irp_pkg::REG_LENGTH:  cfg_d.image_length         = pwdata[23:0];
        irp_pkg::REG_REPORT:  cfg_d.report_id            = pwdata[7:0];
        irp_pkg::REG_DEVICE:  cfg_d.device_index         = pwdata[7:0];
        irp_pkg::REG_SW_DISP: cfg_d.software_and_display = pwdata[11:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      irp_pkg::REG_FEATURE: prdata = {24'd0, cfg_q.feature_index};
      irp_pkg::REG_DEFER:   prdata = {31'd0, cfg_q.defer_update};
      irp_pkg::REG_ORIGIN:  prdata = cfg_q.region_origin;
      irp_pkg::REG_SIZE:    prdata = cfg_q.region_size;
      irp_pkg::REG_LENGTH:  prdata = {8'd0, cfg_q.image_length};
      irp_pkg::REG_REPORT:  prdata = {24'd0, cfg_q.report_id};
      irp_pkg::REG_DEVICE:  prdata = {24'd0, cfg_q.device_index};
      irp_pkg::REG_SW_DISP: prdata = {20'd0, cfg_q.software_and_display};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irp_front #(
    .PACKET_BYTES (PACKET_BYTES),
    .MAX_IMAGE    (MAX_IMAGE),
    .PANEL_SIZE   (PANEL_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_ent_o    (push_ent)
  );

  irp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_ent_i   (push_ent),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_ent_o   (head_ent)
  );

  irp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_ent_i   (head_ent),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .out_eop_o    (out_eop),
    .out_pad_o    (out_pad),
    .out_last_o   (m_axis_tlast),
    .out_rej_o    (out_rej)
  );

  assign m_axis_tdata = {3'd0, out_pad, out_byte};
  assign m_axis_tuser = {out_rej, out_eop};

endmodule
